@@ rtl/assert_macros.svh @@
// Assertion helpers for the barrier path step unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BPE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpe: same-cycle check failed");

// next-cycle implication
`define BPE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpe: next-cycle check failed");

`endif

@@ rtl/bpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types, constants and tables of the barrier path step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bpe_pkg;

  localparam logic [35:0] F_ONE    = 36'h040000000;  // 1.0 in Q30
  localparam logic [30:0] T_ONE    = 31'h40000000;   // 1.0 in Q30
  localparam logic [16:0] W_ONE    = 17'h10000;      // 1.0 in Q1.16
  localparam logic [28:0] EXP_M1   = 29'd395007542;  // exp(-1) in Q30
  localparam logic [21:0] C_CAP    = 22'h200000;     // 32.0 in Q16
  localparam logic [31:0] RND16    = 32'd32768;
  localparam logic [31:0] RND14    = 32'd8192;

  typedef enum logic [2:0] {
    CFG_START   = 3'd0,
    CFG_DRIFT   = 3'd1,
    CFG_VOL     = 3'd2,
    CFG_BARRIER = 3'd3,
    CFG_STRIKE  = 3'd4,
    CFG_SCALE   = 3'd5,
    CFG_MODE    = 3'd6
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_VZ, ST_F, ST_FHI, ST_FLO, ST_PRICE, ST_MUL_D, ST_MUL_PP,
    ST_DIV_INIT, ST_DIV, ST_MUL_C, ST_EXP_INIT, ST_YT, ST_DVC, ST_HORN,
    ST_KMUL, ST_KT, ST_FACTOR, ST_MUL_W, ST_W, ST_FINISH, ST_RESULT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_VZ, OP_F, OP_MUL_FHI, OP_MUL_FLO, OP_PRICE,
    OP_MUL_D, OP_MUL_PP, OP_DIV_INIT, OP_DIV_STEP, OP_MUL_C, OP_EXP_INIT,
    OP_MUL_YT, OP_MUL_DVC, OP_HORN, OP_MUL_K, OP_T_K, OP_FACTOR, OP_MUL_W,
    OP_W, OP_STORE, OP_MUL_PAY, OP_RESULT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] idx;   // divider bit index or series term
  } bpe_cmd_t;

  typedef struct packed {
    logic       cont;
    logic       last;
    logic       special;   // bridge factor known without the series
    logic [5:0] k;         // integer part of the exponent argument
    logic       out_busy;
  } bpe_status_t;

  // ceil(2^33 / i) for the series terms that are not powers of two
  function automatic logic [31:0] horner_recip(input logic [3:0] i);
    logic [31:0] m;
    case (i)
      4'd3:    m = 32'd2863311531;
      4'd5:    m = 32'd1717986919;
      4'd6:    m = 32'd1431655766;
      4'd7:    m = 32'd1227133514;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpe_ctrl
// Sequencer of the step unit: walks the datapath through price update,
// bridge division, exponential series and weight update.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_ctrl import bpe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        out_ready,
  input  wire bpe_status_t status,
  output bpe_cmd_t         cmd
);

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_VZ;
      ST_VZ:       state_nxt = ST_F;
      ST_F:        state_nxt = ST_FHI;
      ST_FHI:      state_nxt = ST_FLO;
      ST_FLO:      state_nxt = ST_PRICE;
      ST_PRICE:    state_nxt = status.cont ? ST_MUL_D : ST_FINISH;
      ST_MUL_D:    state_nxt = status.special ? ST_FACTOR : ST_MUL_PP;
      ST_MUL_PP:   state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: begin
        cnt_nxt   = 6'd31;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == 6'd0) begin
          state_nxt = ST_MUL_C;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      ST_MUL_C:    state_nxt = ST_EXP_INIT;
      ST_EXP_INIT: begin
        cnt_nxt   = 6'd8;
        state_nxt = ST_YT;
      end
      ST_YT:       state_nxt = ST_DVC;
      ST_DVC:      state_nxt = ST_HORN;
      ST_HORN: begin
        if (cnt_r == 6'd1) begin
          // series done, scale by exp(-1) once per integer unit
          if (status.k == 6'd0) begin
            state_nxt = ST_FACTOR;
          end else begin
            cnt_nxt   = status.k;
            state_nxt = ST_KMUL;
          end
        end else begin
          cnt_nxt   = cnt_r - 6'd1;
          state_nxt = ST_YT;
        end
      end
      ST_KMUL:     state_nxt = ST_KT;
      ST_KT: begin
        if (cnt_r == 6'd1) begin
          state_nxt = ST_FACTOR;
        end else begin
          cnt_nxt   = cnt_r - 6'd1;
          state_nxt = ST_KMUL;
        end
      end
      ST_FACTOR:   state_nxt = ST_MUL_W;
      ST_MUL_W:    state_nxt = ST_W;
      ST_W:        state_nxt = ST_FINISH;
      ST_FINISH:   state_nxt = status.last ? ST_RESULT : ST_IDLE;
      ST_RESULT:   if (!status.out_busy || out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    cmd.idx  = cnt_r[4:0];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_VZ:       cmd.op = OP_MUL_VZ;
      ST_F:        cmd.op = OP_F;
      ST_FHI:      cmd.op = OP_MUL_FHI;
      ST_FLO:      cmd.op = OP_MUL_FLO;
      ST_PRICE:    cmd.op = OP_PRICE;
      ST_MUL_D:    cmd.op = OP_MUL_D;
      ST_MUL_PP:   cmd.op = OP_MUL_PP;
      ST_DIV_INIT: cmd.op = OP_DIV_INIT;
      ST_DIV:      cmd.op = OP_DIV_STEP;
      ST_MUL_C:    cmd.op = OP_MUL_C;
      ST_EXP_INIT: cmd.op = OP_EXP_INIT;
      ST_YT:       cmd.op = OP_MUL_YT;
      ST_DVC:      cmd.op = OP_MUL_DVC;
      ST_HORN:     cmd.op = OP_HORN;
      ST_KMUL:     cmd.op = OP_MUL_K;
      ST_KT:       cmd.op = OP_T_K;
      ST_FACTOR:   cmd.op = OP_FACTOR;
      ST_MUL_W:    cmd.op = OP_MUL_W;
      ST_W:        cmd.op = OP_W;
      ST_FINISH:   cmd.op = status.last ? OP_MUL_PAY : OP_STORE;
      ST_RESULT:   if (!status.out_busy || out_ready) cmd.op = OP_RESULT;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/bpe_dp.sv @@
// ----------------------------------------------------------------------------
// bpe_dp
// Datapath of the step unit: configuration registers, path state, one shared
// 33x33 multiplier, restoring divider and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_dp import bpe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic signed [15:0] in_normal_sample,
  input  wire logic               in_last_step,
  input  wire bpe_cmd_t           cmd,
  output bpe_status_t             status,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [31:0]             out_final_value,
  output logic [31:0]             out_path_maximum,
  output logic [16:0]             out_survival_weight,
  output logic [31:0]             out_option_payoff
);

  // configuration
  logic [31:0] start_r, drift_r, barrier_r, strike_r, scale_r;
  logic [30:0] vol_r;
  logic        cont_r;

  // path state
  logic [31:0] asset_r, runmax_r;
  logic [16:0] wprod_r;
  logic        fresh_r;

  // working registers
  logic signed [15:0] z_r;
  logic               last_r;
  logic [31:0]        prev_r, mx_r, s_r;
  logic [16:0]        w_r, factor_r;
  logic [35:0]        f_r;
  logic [51:0]        acc_r;
  logic signed [65:0] prod_r;
  logic [63:0]        p_r, den_r, rem_r;
  logic [31:0]        q_r;
  logic               ovf_r;
  logic [21:0]        c_r;
  logic [30:0]        t_r;
  logic [29:0]        x_r;

  // output word
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_final_r, out_max_r, out_pay_r;
  logic [16:0] out_w_r;

  // combinational helpers
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_nxt;
  logic               mul_en;
  logic signed [65:0] vz_sh;
  logic [35:0]        f_calc;
  logic               f_pos;
  logic [52:0]        price_sum;
  logic [38:0]        price_r39;
  logic [31:0]        price_s;
  logic [31:0]        d1, d2;
  logic               touch, zscale, pzero, special;
  logic [16:0]        sfactor;
  logic               nb;
  logic [64:0]        rem_sh, rem_diff;
  logic               rem_ge;
  logic [31:0]        ratio;
  logic [51:0]        c_full;
  logic [29:0]        horn_q;
  logic [31:0]        t_rnd;
  logic [31:0]        pay_base;
  logic [33:0]        w_sum;
  logic [48:0]        pay_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= 32'd6553600;
      drift_r   <= '0;
      vol_r     <= '0;
      barrier_r <= 32'hFFFFFFFF;
      strike_r  <= 32'd6553600;
      scale_r   <= '0;
      cont_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START:   start_r   <= cfg_data;
        CFG_DRIFT:   drift_r   <= cfg_data;
        CFG_VOL:     vol_r     <= cfg_data[30:0];
        CFG_BARRIER: barrier_r <= cfg_data;
        CFG_STRIKE:  strike_r  <= cfg_data;
        CFG_SCALE:   scale_r   <= cfg_data;
        CFG_MODE:    cont_r    <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // price update
  assign vz_sh     = prod_r >>> 12;
  assign f_calc    = F_ONE + {{4{drift_r[31]}}, drift_r} + vz_sh[35:0];
  assign f_pos     = !f_r[35] && (f_r != 36'd0);
  assign price_sum = {1'b0, acc_r} + {21'd0, prod_r[47:16]};
  assign price_r39 = price_sum[52:14];
  assign price_s   = !f_pos ? 32'd0 :
                     (|price_r39[38:32]) ? 32'hFFFFFFFF : price_r39[31:0];

  // bridge special cases
  assign d1      = (prev_r > barrier_r) ? prev_r - barrier_r : barrier_r - prev_r;
  assign d2      = (s_r > barrier_r) ? s_r - barrier_r : barrier_r - s_r;
  assign touch   = (prev_r == barrier_r) || (s_r == barrier_r) ||
                   ((prev_r > barrier_r) != (s_r > barrier_r));
  assign zscale  = (scale_r == 32'd0);
  assign pzero   = (prev_r == 32'd0);
  assign special = touch || zscale || pzero;
  assign sfactor = (touch || zscale) ? 17'd0 : W_ONE;

  // divider step: bring in the low dividend bits, then zeros
  assign nb       = cmd.idx[4] ? p_r[cmd.idx[3:0]] : 1'b0;
  assign rem_sh   = {rem_r, nb};
  assign rem_ge   = rem_sh >= {1'b0, den_r};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign ratio    = ovf_r ? 32'hFFFFFFFF : q_r;
  assign c_full   = prod_r[63:12];

  always_comb begin
    case (cmd.idx[3:0])
      4'd1:    horn_q = x_r;
      4'd2:    horn_q = {1'b0, x_r[29:1]};
      4'd4:    horn_q = {2'b0, x_r[29:2]};
      4'd8:    horn_q = {3'b0, x_r[29:3]};
      default: horn_q = prod_r[62:33];
    endcase
  end

  assign t_rnd    = {1'b0, t_r} + RND14;
  assign pay_base = ((mx_r <= barrier_r) && (s_r > strike_r)) ? s_r - strike_r : 32'd0;
  assign w_sum    = prod_r[33:0] + {2'b0, RND16};
  assign pay_sum  = prod_r[48:0] + {17'd0, RND16};

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_MUL_VZ: begin
        mul_a = {2'b0, vol_r};
        mul_b = {{17{z_r[15]}}, z_r};
      end
      OP_MUL_FHI: begin
        mul_a = {1'b0, prev_r};
        mul_b = {13'd0, f_r[35:16]};
      end
      OP_MUL_FLO: begin
        mul_a = {1'b0, prev_r};
        mul_b = {17'd0, f_r[15:0]};
      end
      OP_MUL_D: begin
        mul_a = {1'b0, d1};
        mul_b = {1'b0, d2};
      end
      OP_MUL_PP: begin
        mul_a = {1'b0, prev_r};
        mul_b = {1'b0, prev_r};
      end
      OP_MUL_C: begin
        mul_a = {1'b0, scale_r};
        mul_b = {1'b0, ratio};
      end
      OP_MUL_YT: begin
        mul_a = {3'b0, c_r[15:0], 14'd0};
        mul_b = {2'b0, t_r};
      end
      OP_MUL_DVC: begin
        mul_a = {3'b0, prod_r[59:30]};
        mul_b = {1'b0, horner_recip(cmd.idx[3:0])};
      end
      OP_MUL_K: begin
        mul_a = {2'b0, t_r};
        mul_b = {4'b0, EXP_M1};
      end
      OP_MUL_W: begin
        mul_a = {16'd0, w_r};
        mul_b = {16'd0, factor_r};
      end
      OP_MUL_PAY: begin
        mul_a = {1'b0, pay_base};
        mul_b = {16'd0, w_r};
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= prod_nxt;
    case (cmd.op)
      OP_LOAD: begin
        z_r    <= in_normal_sample;
        last_r <= in_last_step;
        prev_r <= fresh_r ? start_r : asset_r;
        mx_r   <= fresh_r ? start_r : runmax_r;
        w_r    <= fresh_r ? W_ONE : wprod_r;
      end
      OP_F:       f_r   <= f_calc;
      OP_MUL_FLO: acc_r <= prod_r[51:0];
      OP_PRICE: begin
        s_r  <= price_s;
        mx_r <= (price_s > mx_r) ? price_s : mx_r;
      end
      OP_MUL_PP:  p_r <= prod_r[63:0];
      OP_DIV_INIT: begin
        den_r <= prod_r[63:0];
        rem_r <= {16'd0, p_r[63:16]};
        ovf_r <= {16'd0, p_r[63:16]} >= prod_r[63:0];
        q_r   <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= rem_ge ? rem_diff[63:0] : rem_sh[63:0];
        q_r   <= {q_r[30:0], rem_ge};
      end
      OP_EXP_INIT: begin
        c_r <= (c_full > {30'd0, C_CAP}) ? C_CAP : c_full[21:0];
        t_r <= T_ONE;
      end
      OP_MUL_DVC: x_r <= prod_r[59:30];
      OP_HORN:    t_r <= T_ONE - {1'b0, horn_q};
      OP_T_K:     t_r <= prod_r[60:30];
      OP_FACTOR:  factor_r <= special ? sfactor : W_ONE - t_rnd[30:14];
      OP_W:       w_r <= w_sum[32:16];
      OP_STORE: begin
        asset_r  <= s_r;
        runmax_r <= mx_r;
        wprod_r  <= w_r;
      end
      OP_RESULT: begin
        out_final_r <= s_r;
        out_max_r   <= mx_r;
        out_w_r     <= w_r;
        out_pay_r   <= cont_r ? pay_sum[47:16] : pay_base;
      end
      default: ;
    endcase
  end

  // hold the result word until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op == OP_RESULT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.op == OP_STORE) fresh_r <= 1'b0;
      if (cmd.op == OP_RESULT) fresh_r <= 1'b1;
    end
  end

  assign status.cont     = cont_r;
  assign status.last     = last_r;
  assign status.special  = special;
  assign status.k        = c_r[21:16];
  assign status.out_busy = out_valid_r;

  assign out_valid           = out_valid_r;
  assign out_final_value     = out_final_r;
  assign out_path_maximum    = out_max_r;
  assign out_survival_weight = out_w_r;
  assign out_option_payoff   = out_pay_r;

endmodule

`default_nettype wire

@@ rtl/barrier_path_euler_step_unit.sv @@
// ----------------------------------------------------------------------------
// barrier_path_euler_step_unit
// One Euler step of an up-and-out call path per input word, with optional
// Brownian bridge survival weighting; one result word per finished path.
// ----------------------------------------------------------------------------
// Input channel in_*: one normal sample per time step; in_last_step closes
// the path. Result channel out_*: final price, path maximum, survival weight
// and payoff, one word per path. cfg_*: write-only register port, one
// register per cycle; the user is to write only while no path step is in
// flight, and the block itself does not enforce it. The work per input
// word is set by the single shared multiplier and the one-bit-per-cycle
// divider. Discrete mode skips the bridge. In continuous mode a touched
// or crossed barrier, a zero bridge scale or a zero previous price skips
// the division and the series; all other steps run the divider, the
// series and k multiplications by exp(-1), k = integer part of the bridge
// exponent, up to 32. A last step also passes through the result state,
// which loads the result register. A new word is accepted while a result
// still waits in the output register; a finished path holds the sequencer
// only if that register is still full. Reset restores the configuration,
// sequencer and output-valid registers to their defaults and starts a
// fresh path from the start price register; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module barrier_path_euler_step_unit import bpe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_normal_sample,
  input  wire logic               in_last_step,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_final_value,
  output logic [31:0]             out_path_maximum,
  output logic [16:0]             out_survival_weight,
  output logic [31:0]             out_option_payoff
);

  bpe_cmd_t    cmd;
  bpe_status_t status;

  bpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bpe_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_normal_sample    (in_normal_sample),
    .in_last_step        (in_last_step),
    .cmd                 (cmd),
    .status              (status),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_final_value     (out_final_value),
    .out_path_maximum    (out_path_maximum),
    .out_survival_weight (out_survival_weight),
    .out_option_payoff   (out_option_payoff)
  );

  `BPE_ASSERT_NXT(a_accept_then_busy, in_valid && in_ready, !in_ready)
  `BPE_ASSERT_IMP(a_result_slot_free, cmd.op == OP_RESULT, !out_valid || out_ready)
  `BPE_ASSERT_IMP(a_max_covers_final, out_valid, out_path_maximum >= out_final_value)
  `BPE_ASSERT_IMP(a_payoff_below_price, out_valid, out_option_payoff <= out_final_value)

endmodule

`default_nettype wire
